[src/bfmc_pkg.sv]
// Shared types, constants and helpers for the 2x2 box-filter mip chain block.
package bfmc_pkg;

    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_LEVELS_DEF = 13;
    localparam int DIM_CAP        = 4096;   // largest base width or height

    localparam int DIM_W      = 13;         // width/height register width
    localparam int POS_W      = 12;         // column/row counter width
    localparam int LEVEL_W    = 4;          // level field and level count width
    localparam int PIX_W      = 32;         // packed RGBA8, red in the low byte
    localparam int LANE_W     = 9;          // one channel of a pair sum
    localparam int PAIR_W     = 4 * LANE_W; // four channel pair sums
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_LEVEL_COUNT  = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_MEAN
    } state_t;

    typedef enum logic {
        ALU_PAIR,
        ALU_MEAN
    } alu_op_t;

    typedef struct packed {
        logic idle;
        logic take;
        logic emit;
        logic mean;
    } bfmc_ctrl_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pixel_in_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic [7:0]         out_red;
        logic [7:0]         out_green;
        logic [7:0]         out_blue;
        logic [7:0]         out_alpha;
        logic               run_last;
    } pixel_out_t;

    // Spread a packed RGBA8 pixel over four 9-bit lanes.
    function automatic logic [PAIR_W-1:0] expand_pix(input logic [PIX_W-1:0] p);
        logic [PAIR_W-1:0] r;
        r = '0;
        for (int c = 0; c < 4; c++) begin
            r[LANE_W*c +: LANE_W] = {1'b0, p[8*c +: 8]};
        end
        return r;
    endfunction

endpackage

[src/bfmc_pair_ram.sv]
// Pair-sum line store: one write port, one registered read port.
module bfmc_pair_ram #(
    parameter int DEPTH = bfmc_pkg::MAX_WIDTH_DEF,
    parameter int AW    = $clog2(bfmc_pkg::MAX_WIDTH_DEF)
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [bfmc_pkg::PAIR_W-1:0] wdata,
    input  logic                        re,
    input  logic [AW-1:0]               raddr,
    output logic [bfmc_pkg::PAIR_W-1:0] rdata
);

    logic [bfmc_pkg::PAIR_W-1:0] mem_reg [DEPTH];
    logic [bfmc_pkg::PAIR_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/bfmc_avg_unit.sv]
// Shared four-lane adder: pair sums of two pixels, or the mean of four pixels from two pair sums.
module bfmc_avg_unit (
    input  bfmc_pkg::alu_op_t           op,
    input  logic [bfmc_pkg::PAIR_W-1:0] a,
    input  logic [bfmc_pkg::PAIR_W-1:0] b,
    output logic [bfmc_pkg::PAIR_W-1:0] result
);

    always_comb
    begin
        logic [bfmc_pkg::LANE_W:0] s;
        result = '0;
        for (int c = 0; c < 4; c++) begin
            s = {1'b0, a[bfmc_pkg::LANE_W*c +: bfmc_pkg::LANE_W]}
              + {1'b0, b[bfmc_pkg::LANE_W*c +: bfmc_pkg::LANE_W]};
            case (op)
                bfmc_pkg::ALU_MEAN: result[8*c +: 8] = s[9:2];
                default:            result[bfmc_pkg::LANE_W*c +: bfmc_pkg::LANE_W] = s[8:0];
            endcase
        end
    end

endmodule

[src/bfmc_ctrl.sv]
// Sequencer: accept a pixel, then walk the levels one emit/mean pair at a time.
module bfmc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 out_busy,   // output register full and stalled
    input  logic                 go_on,      // this level feeds the next one
    output bfmc_pkg::bfmc_ctrl_t ctrl
);

    bfmc_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bfmc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bfmc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = bfmc_pkg::ST_EMIT;
                end
            end
            bfmc_pkg::ST_EMIT:
            begin
                if (!out_busy)
                begin
                    state_next = go_on ? bfmc_pkg::ST_MEAN : bfmc_pkg::ST_IDLE;
                end
            end
            bfmc_pkg::ST_MEAN: state_next = bfmc_pkg::ST_EMIT;
            default:           state_next = bfmc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        case (state_reg)
            bfmc_pkg::ST_IDLE:
            begin
                ctrl.idle = 1'b1;
                ctrl.take = in_valid;
            end
            bfmc_pkg::ST_EMIT: ctrl.emit = !out_busy;
            bfmc_pkg::ST_MEAN: ctrl.mean = 1'b1;
            default:           ctrl = '0;
        endcase
    end

endmodule

[src/box_filter_mip_chain_core.sv]
// Top level of the streaming 2x2 box-filter mip chain generator.
// Timing: a level 0 result enters the output register from the emit step after its pixel transfer;
//   each further level of the cascade adds one mean and one emit step; an emit waits out a stall.
// Input: a new pixel is taken only once the sequencer is idle again, after every level it
//   cascades into is emitted; the single sequencer and the shared lane adder handle one level at a time.
// Reset: asynchronous, active low; registers go to 1/1/1, all level positions to (0,0).
module box_filter_mip_chain_core #(
    parameter int MAX_WIDTH  = bfmc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_LEVELS = bfmc_pkg::MAX_LEVELS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // pixel input
    input  logic                            in_valid,
    output logic                            in_stall,
    input  bfmc_pkg::pixel_in_t             in_data,
    // mip pixel output
    output logic                            out_valid,
    input  logic                            out_stall,
    output bfmc_pkg::pixel_out_t            out_data,
    // register writes
    input  logic                            cfg_we,
    input  logic [bfmc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bfmc_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int AW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int LIDX_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int W_CAP  = (MAX_WIDTH < bfmc_pkg::DIM_CAP) ? MAX_WIDTH : bfmc_pkg::DIM_CAP;

    localparam int DW = bfmc_pkg::DIM_W;
    localparam int PW = bfmc_pkg::POS_W;
    localparam int LW = bfmc_pkg::LEVEL_W;

    // ------------------------------------------------------------------
    // Configuration registers. A write to any of the three resets all level positions.
    // ------------------------------------------------------------------
    logic [DW-1:0] width_reg;
    logic [DW-1:0] height_reg;
    logic [LW-1:0] levels_reg;
    logic          cfg_hit;

    always_comb
    begin
        case (cfg_index)
            bfmc_pkg::REG_IMAGE_WIDTH,
            bfmc_pkg::REG_IMAGE_HEIGHT,
            bfmc_pkg::REG_LEVEL_COUNT: cfg_hit = cfg_we;
            default:                   cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DW'(1);
            height_reg <= DW'(1);
            levels_reg <= LW'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bfmc_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                bfmc_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                bfmc_pkg::REG_LEVEL_COUNT:  levels_reg <= cfg_data[LW-1:0];
                default:                    ;
            endcase
        end
    end

    // Clamp to the legal ranges.
    logic [DW-1:0] w0;
    logic [DW-1:0] h0;
    logic [LW-1:0] levels_c;

    always_comb
    begin
        if (width_reg == '0)
            w0 = DW'(1);
        else if (int'(width_reg) > W_CAP)
            w0 = DW'(W_CAP);
        else
            w0 = width_reg;

        if (height_reg == '0)
            h0 = DW'(1);
        else if (int'(height_reg) > bfmc_pkg::DIM_CAP)
            h0 = DW'(bfmc_pkg::DIM_CAP);
        else
            h0 = height_reg;

        if (levels_reg == '0)
            levels_c = LW'(1);
        else if (int'(levels_reg) > MAX_LEVELS)
            levels_c = LW'(MAX_LEVELS);
        else
            levels_c = levels_reg;
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    bfmc_pkg::bfmc_ctrl_t ctrl_s;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_busy;
    logic                 go_on;

    assign out_busy = out_valid_reg && out_stall;

    bfmc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_busy (out_busy),
        .go_on    (go_on),
        .ctrl     (ctrl_s)
    );

    assign in_stall = !ctrl_s.idle;

    // ------------------------------------------------------------------
    // Per-level state
    // ------------------------------------------------------------------
    logic [bfmc_pkg::PIX_W-1:0]  pix_reg;
    logic [LIDX_W-1:0]           lvl_reg;
    logic [bfmc_pkg::PAIR_W-1:0] pair_reg;
    logic [bfmc_pkg::PIX_W-1:0]  hold_reg [MAX_LEVELS];
    logic [PW-1:0]               col_reg  [MAX_LEVELS];
    logic [PW-1:0]               row_reg  [MAX_LEVELS];

    // Current level geometry and position; a stale position wraps to (0,0).
    logic [DW-1:0] w_lvl;
    logic [DW-1:0] h_lvl;
    logic [PW-1:0] col_eff;
    logic [PW-1:0] row_eff;
    logic [PW-1:0] col_upd;
    logic [PW-1:0] row_upd;
    logic [DW-1:0] col_inc;
    logic [DW-1:0] row_inc;
    logic          col_odd;
    logic          row_odd;
    logic [AW-1:0] pair_addr;

    assign w_lvl = w0 >> lvl_reg;
    assign h_lvl = h0 >> lvl_reg;

    always_comb
    begin
        col_eff = col_reg[lvl_reg];
        row_eff = row_reg[lvl_reg];
        if ({1'b0, col_eff} >= w_lvl || {1'b0, row_eff} >= h_lvl)
        begin
            col_eff = '0;
            row_eff = '0;
        end

        col_inc = {1'b0, col_eff} + DW'(1);
        row_inc = {1'b0, row_eff} + DW'(1);
        col_upd = col_inc[PW-1:0];
        row_upd = row_eff;
        if (col_inc >= w_lvl)
        begin
            col_upd = '0;
            row_upd = (row_inc >= h_lvl) ? '0 : row_inc[PW-1:0];
        end
    end

    assign col_odd = col_eff[0];
    assign row_odd = row_eff[0];

    // Level s keeps its pair sums in its own slice of the line store.
    assign pair_addr = AW'(MAX_WIDTH - (MAX_WIDTH >> lvl_reg) + int'(col_eff[PW-1:1]));

    // A finished 2x2 block feeds the next level, if one is produced.
    assign go_on = col_odd && row_odd && (int'(lvl_reg) + 1 < int'(levels_c));

    // ------------------------------------------------------------------
    // Shared lane adder: pair sum while emitting, mean in the mean step
    // ------------------------------------------------------------------
    bfmc_pkg::alu_op_t           alu_op;
    logic [bfmc_pkg::PAIR_W-1:0] alu_a;
    logic [bfmc_pkg::PAIR_W-1:0] alu_b;
    logic [bfmc_pkg::PAIR_W-1:0] alu_res;
    logic [bfmc_pkg::PAIR_W-1:0] ram_rdata;

    always_comb
    begin
        if (ctrl_s.mean)
        begin
            alu_op = bfmc_pkg::ALU_MEAN;
            alu_a  = ram_rdata;
            alu_b  = pair_reg;
        end
        else
        begin
            alu_op = bfmc_pkg::ALU_PAIR;
            alu_a  = bfmc_pkg::expand_pix(hold_reg[lvl_reg]);
            alu_b  = bfmc_pkg::expand_pix(pix_reg);
        end
    end

    bfmc_avg_unit u_avg (
        .op     (alu_op),
        .a      (alu_a),
        .b      (alu_b),
        .result (alu_res)
    );

    bfmc_pair_ram #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ctrl_s.emit && col_odd && !row_odd),
        .waddr (pair_addr),
        .wdata (alu_res),
        .re    (ctrl_s.emit && col_odd && row_odd),
        .raddr (pair_addr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (ctrl_s.take)
        begin
            pix_reg <= {in_data.alpha, in_data.blue, in_data.green, in_data.red};
        end
        else if (ctrl_s.mean)
        begin
            pix_reg <= alu_res[bfmc_pkg::PIX_W-1:0];
        end

        if (ctrl_s.emit)
        begin
            pair_reg <= alu_res;
        end

        if (ctrl_s.emit && !col_odd)
        begin
            hold_reg[lvl_reg] <= pix_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lvl_reg <= '0;
        end
        else if (ctrl_s.take)
        begin
            lvl_reg <= '0;
        end
        else if (ctrl_s.mean)
        begin
            lvl_reg <= lvl_reg + LIDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_LEVELS; i++) begin
                col_reg[i] <= '0;
                row_reg[i] <= '0;
            end
        end
        else if (cfg_hit)
        begin
            for (int i = 0; i < MAX_LEVELS; i++) begin
                col_reg[i] <= '0;
                row_reg[i] <= '0;
            end
        end
        else if (ctrl_s.emit)
        begin
            col_reg[lvl_reg] <= col_upd;
            row_reg[lvl_reg] <= row_upd;
        end
    end

    // ------------------------------------------------------------------
    // Output register: holds one result while the sequencer waits
    // ------------------------------------------------------------------
    bfmc_pkg::pixel_out_t out_data_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (ctrl_s.emit)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_s.emit)
        begin
            out_data_reg.level     <= LW'(lvl_reg);
            out_data_reg.pos_x     <= col_eff;
            out_data_reg.pos_y     <= row_eff;
            out_data_reg.out_red   <= pix_reg[7:0];
            out_data_reg.out_green <= pix_reg[15:8];
            out_data_reg.out_blue  <= pix_reg[23:16];
            out_data_reg.out_alpha <= pix_reg[31:24];
            out_data_reg.run_last  <= !go_on;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    // The mean step only ever follows an emit step.
    a_mean_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_s.mean |-> $past(ctrl_s.emit))
        else $error("mean step without a preceding emit");

    // A result is never loaded over one that is still stalled.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_s.emit |-> !(out_valid_reg && out_stall))
        else $error("output register overwritten while stalled");

    // The last result of a pixel returns the sequencer to idle.
    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_s.emit && !go_on) |=> ctrl_s.idle)
        else $error("sequencer did not return to idle after last result");

    // Output valid only rises from an emit step.
    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(ctrl_s.emit))
        else $error("output valid rose without an emit");
`endif

endmodule
